>>> rtl/mwsi_pkg.sv
// Shared types and constants of the maximum window sum unit.
`timescale 1ns / 1ps
package mwsi_pkg;
    localparam int MAX_INTERVALS = 1024;
    localparam int IDX_W         = $clog2(MAX_INTERVALS);
    localparam int COUNT_W       = IDX_W + 1;
    localparam int PAIR_W        = COUNT_W + 1;
    localparam int BS_W          = COUNT_W + 2;
    localparam int POSITION_BITS = 30;
    localparam int WEIGHT_BITS   = 10;
    localparam int WINDOW_BITS   = 30;
    localparam int SUM_OUT_W     = 40;
    localparam int SUM_W         = POSITION_BITS + WEIGHT_BITS + COUNT_W;
    localparam int LIM_W         = POSITION_BITS + 3;
    localparam int SPAN_W        = POSITION_BITS + 1;
    localparam int PROD_W        = SPAN_W + WEIGHT_BITS;
    localparam int FQ_DEPTH      = 4;
    localparam int FQ_AW         = $clog2(FQ_DEPTH);
    localparam int OQ_DEPTH      = 2;
    localparam int OQ_AW         = $clog2(OQ_DEPTH);

    typedef struct packed {
        logic [POSITION_BITS-1:0] left_end;
        logic [POSITION_BITS-1:0] right_end;
        logic [WEIGHT_BITS-1:0]   weight_per_position;
        logic                     last_interval;
    } t_in_item;

    typedef struct packed {
        logic [SUM_OUT_W-1:0] best_window_sum;
        logic                 capacity_exceeded;
    } t_out_item;

    // Field order gives the sort order when compared as one vector.
    typedef struct packed {
        logic [POSITION_BITS-1:0] l;
        logic [POSITION_BITS-1:0] r;
        logic [WEIGHT_BITS-1:0]   w;
    } t_entry;

    typedef struct packed {
        t_in_item item;
        logic     keep;
    } t_cmd;
endpackage

>>> rtl/mwsi_front.sv
// Input queue that marks each interval as stored or dropped by set capacity.
`timescale 1ns / 1ps
module mwsi_front import mwsi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_item i_in_item,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);
    t_cmd             r_q [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wp;
    logic [FQ_AW-1:0] r_rp;
    logic [FQ_AW:0]   r_cnt;
    logic [COUNT_W-1:0] r_set;
    logic push_ok;
    logic pop_ok;
    logic keep;

    assign o_full      = (r_cnt == (FQ_AW + 1)'(FQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign push_ok     = i_push & ~o_full;
    assign pop_ok      = i_cmd_pop & o_cmd_valid;
    assign keep        = (r_set < COUNT_W'(MAX_INTERVALS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_set <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
                if (i_in_item.last_interval) begin
                    r_set <= '0;
                end else if (keep) begin
                    r_set <= r_set + 1'b1;
                end
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= '{item: i_in_item, keep: keep};
        end
    end
endmodule

>>> rtl/mwsi_outq.sv
// Result queue between the compute engine and the result port.
`timescale 1ns / 1ps
module mwsi_outq import mwsi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_data,
    output logic      o_full,
    output logic      o_empty,
    output t_out_item o_data,
    input  logic      i_pop
);
    t_out_item        r_q [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp;
    logic [OQ_AW-1:0] r_rp;
    logic [OQ_AW:0]   r_cnt;
    logic push_ok;
    logic pop_ok;

    assign o_full  = (r_cnt == (OQ_AW + 1)'(OQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_q[r_rp];
    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= i_data;
        end
    end
endmodule

>>> rtl/mwsi_back.sv
// Compute engine: storage, merge sort, prefix sums and binary-search window scan.
`timescale 1ns / 1ps
module mwsi_back import mwsi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [WINDOW_BITS-1:0] i_window_length,
    input  logic                   i_cmd_valid,
    input  t_cmd                   i_cmd,
    output logic                   o_cmd_pop,
    output logic                   o_res_push,
    output t_out_item              o_res,
    input  logic                   i_res_full
);
    typedef enum logic [17:0] {
        S_LOAD  = 18'h00001,
        S_SPASS = 18'h00002,
        S_SPAIR = 18'h00004,
        S_SRD   = 18'h00008,
        S_SCMP  = 18'h00010,
        S_PINIT = 18'h00020,
        S_PRD   = 18'h00040,
        S_PWS   = 18'h00080,
        S_PWM   = 18'h00100,
        S_PWA   = 18'h00200,
        S_WRD   = 18'h00400,
        S_WSET  = 18'h00800,
        S_QST   = 18'h01000,
        S_BRD   = 18'h02000,
        S_BCMP  = 18'h04000,
        S_FRD   = 18'h08000,
        S_QRES  = 18'h10000,
        S_OUT   = 18'h20000
    } t_state;

    t_entry             r_ent [2*MAX_INTERVALS];
    logic [SUM_W-1:0]   r_pre [MAX_INTERVALS+1];
    t_entry             r_rda;
    t_entry             r_rdb;
    logic [SUM_W-1:0]   r_rdp;

    t_state             r_state;
    logic [COUNT_W-1:0] r_cnt;
    logic               r_drop;
    logic               r_bank;
    logic [PAIR_W-1:0]  r_w;
    logic [PAIR_W-1:0]  r_lo;
    logic [PAIR_W-1:0]  r_i;
    logic [PAIR_W-1:0]  r_j;
    logic [PAIR_W-1:0]  r_o;
    logic [PAIR_W-1:0]  r_imid;
    logic [PAIR_W-1:0]  r_jend;
    logic               r_mode;
    logic [SUM_W-1:0]   r_acc;
    logic [SPAN_W-1:0]  r_span;
    logic [WEIGHT_BITS-1:0] r_wt;
    logic [SUM_W-1:0]   r_base;
    logic [PROD_W-1:0]  r_prod;
    logic [SUM_W-1:0]   r_val;
    logic [SUM_W-1:0]   r_a;
    logic [SUM_W-1:0]   r_best;
    logic [POSITION_BITS-1:0] r_cur_l;
    logic [POSITION_BITS-1:0] r_cur_r;
    logic [1:0]         r_q;
    logic signed [LIM_W-1:0] r_lim;
    logic signed [BS_W-1:0]  r_bs_lo;
    logic signed [BS_W-1:0]  r_bs_hi;
    logic [IDX_W-1:0]   r_mid;
    logic [IDX_W-1:0]   r_found;
    logic               r_fvalid;

    logic               ent_we;
    logic [IDX_W:0]     ent_waddr;
    t_entry             ent_wdata;
    logic               rda_en;
    logic [IDX_W:0]     rda_addr;
    logic               rdb_en;
    logic [IDX_W:0]     rdb_addr;
    logic               pre_we;
    logic [COUNT_W-1:0] pre_waddr;
    logic [SUM_W-1:0]   pre_wdata;
    logic               pre_re;

    logic [PAIR_W-1:0]  n_pair;
    logic [PAIR_W-1:0]  lo_w;
    logic [PAIR_W-1:0]  lo_2w;
    logic               take_i;
    logic [COUNT_W-1:0] i_next;
    logic signed [BS_W-1:0]  bs_sum;
    logic [IDX_W-1:0]   mid;
    logic signed [LIM_W-1:0] ls;
    logic signed [LIM_W-1:0] rs;
    logic signed [LIM_W-1:0] ks;
    logic signed [LIM_W-1:0] hi_pos;
    logic signed [LIM_W-1:0] span_s;
    logic signed [LIM_W-1:0] q_end;
    logic signed [LIM_W-1:0] q_lim;
    logic signed [LIM_W-1:0] left_s;
    logic [SUM_W-1:0]   pw_sum;
    logic [SUM_W-1:0]   diff;
    logic [COUNT_W-1:0] cnt_inc;

    assign n_pair  = PAIR_W'(r_cnt);
    assign lo_w    = r_lo + r_w;
    assign lo_2w   = r_lo + (r_w << 1);
    assign take_i  = (r_i < r_imid) && ((r_j >= r_jend) || !(r_rdb < r_rda));
    assign i_next  = r_i[COUNT_W-1:0] + 1'b1;
    assign bs_sum  = r_bs_lo + r_bs_hi;
    assign mid     = bs_sum[IDX_W:1];
    assign ls      = LIM_W'(r_rda.l);
    assign rs      = LIM_W'(r_rda.r);
    assign ks      = LIM_W'(i_window_length);
    assign hi_pos  = (r_mode && (r_lim < rs)) ? r_lim : rs;
    assign span_s  = hi_pos - ls + LIM_W'(1);
    assign q_end   = r_q[1] ? (LIM_W'(r_cur_l) + ks - LIM_W'(1)) : LIM_W'(r_cur_r);
    assign q_lim   = r_q[0] ? (q_end - ks) : q_end;
    assign left_s  = LIM_W'(r_rda.l);
    assign pw_sum  = r_base + SUM_W'(r_prod);
    assign diff    = (r_a > r_val) ? (r_a - r_val) : '0;
    assign cnt_inc = r_cnt + 1'b1;

    always_comb begin
        o_cmd_pop  = 1'b0;
        ent_we     = 1'b0;
        ent_waddr  = '0;
        ent_wdata  = r_rda;
        rda_en     = 1'b0;
        rda_addr   = '0;
        rdb_en     = 1'b0;
        rdb_addr   = '0;
        pre_we     = 1'b0;
        pre_waddr  = '0;
        pre_wdata  = pw_sum;
        pre_re     = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.keep) begin
                        ent_we    = 1'b1;
                        ent_waddr = {1'b0, r_cnt[IDX_W-1:0]};
                        ent_wdata = '{l: i_cmd.item.left_end, r: i_cmd.item.right_end,
                                      w: i_cmd.item.weight_per_position};
                    end
                end
            end
            S_SRD: begin
                if (r_o != r_jend) begin
                    rda_en   = 1'b1;
                    rda_addr = {r_bank, r_i[IDX_W-1:0]};
                    rdb_en   = 1'b1;
                    rdb_addr = {r_bank, r_j[IDX_W-1:0]};
                end
            end
            S_SCMP: begin
                ent_we    = 1'b1;
                ent_waddr = {~r_bank, r_o[IDX_W-1:0]};
                ent_wdata = take_i ? r_rda : r_rdb;
            end
            S_PINIT: begin
                pre_we    = 1'b1;
                pre_wdata = '0;
            end
            S_PRD, S_WRD: begin
                rda_en   = 1'b1;
                rda_addr = {r_bank, r_i[IDX_W-1:0]};
            end
            S_PWA: begin
                if (!r_mode) begin
                    pre_we    = 1'b1;
                    pre_waddr = i_next;
                end
            end
            S_BRD: begin
                if (r_bs_lo <= r_bs_hi) begin
                    rda_en   = 1'b1;
                    rda_addr = {r_bank, mid};
                end
            end
            S_FRD: begin
                rda_en   = 1'b1;
                rda_addr = {r_bank, r_found};
                pre_re   = 1'b1;
            end
            S_OUT: begin
                o_res_push = ~i_res_full;
            end
            default: begin
            end
        endcase
    end

    assign o_res.best_window_sum   = (r_best > SUM_W'({SUM_OUT_W{1'b1}})) ?
                                     {SUM_OUT_W{1'b1}} : r_best[SUM_OUT_W-1:0];
    assign o_res.capacity_exceeded = r_drop;

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent[ent_waddr] <= ent_wdata;
        end
        if (rda_en) begin
            r_rda <= r_ent[rda_addr];
        end
        if (rdb_en) begin
            r_rdb <= r_ent[rdb_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pre_we) begin
            r_pre[pre_waddr] <= pre_wdata;
        end
        if (pre_re) begin
            r_rdp <= r_pre[COUNT_W'(r_found)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_bank  <= 1'b0;
            r_w     <= PAIR_W'(1);
            r_best  <= '0;
            r_mode  <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.keep) begin
                            r_cnt <= cnt_inc;
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_cmd.item.last_interval) begin
                            r_state <= S_SPASS;
                        end
                    end
                end
                S_SPASS: begin
                    if (r_w >= n_pair) begin
                        r_state <= S_PINIT;
                    end else begin
                        r_lo    <= '0;
                        r_state <= S_SPAIR;
                    end
                end
                S_SPAIR: begin
                    if (r_lo >= n_pair) begin
                        r_w     <= r_w << 1;
                        r_bank  <= ~r_bank;
                        r_state <= S_SPASS;
                    end else begin
                        r_i     <= r_lo;
                        r_o     <= r_lo;
                        r_imid  <= (lo_w < n_pair) ? lo_w : n_pair;
                        r_j     <= (lo_w < n_pair) ? lo_w : n_pair;
                        r_jend  <= (lo_2w < n_pair) ? lo_2w : n_pair;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    if (r_o == r_jend) begin
                        r_lo    <= r_jend;
                        r_state <= S_SPAIR;
                    end else begin
                        r_state <= S_SCMP;
                    end
                end
                S_SCMP: begin
                    r_o <= r_o + 1'b1;
                    if (take_i) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                    r_state <= S_SRD;
                end
                S_PINIT: begin
                    r_i     <= '0;
                    r_acc   <= '0;
                    r_mode  <= 1'b0;
                    r_state <= S_PRD;
                end
                S_PRD: begin
                    r_state <= S_PWS;
                end
                S_PWS: begin
                    r_span  <= (hi_pos < ls) ? '0 : span_s[SPAN_W-1:0];
                    r_wt    <= r_rda.w;
                    r_base  <= r_mode ? r_rdp : r_acc;
                    r_state <= S_PWM;
                end
                S_PWM: begin
                    r_prod  <= r_span * r_wt;
                    r_state <= S_PWA;
                end
                S_PWA: begin
                    if (r_mode) begin
                        r_val   <= pw_sum;
                        r_state <= S_QRES;
                    end else begin
                        r_acc <= pw_sum;
                        if (i_next == r_cnt) begin
                            r_i     <= '0;
                            r_best  <= '0;
                            r_state <= S_WRD;
                        end else begin
                            r_i     <= PAIR_W'(i_next);
                            r_state <= S_PRD;
                        end
                    end
                end
                S_WRD: begin
                    r_state <= S_WSET;
                end
                S_WSET: begin
                    r_cur_l <= r_rda.l;
                    r_cur_r <= r_rda.r;
                    r_q     <= 2'd0;
                    r_state <= S_QST;
                end
                S_QST: begin
                    r_lim    <= q_lim;
                    r_bs_lo  <= '0;
                    r_bs_hi  <= BS_W'(r_cnt) - BS_W'(1);
                    r_fvalid <= 1'b0;
                    r_state  <= S_BRD;
                end
                S_BRD: begin
                    if (r_bs_lo <= r_bs_hi) begin
                        r_mid   <= mid;
                        r_state <= S_BCMP;
                    end else if (r_fvalid) begin
                        r_state <= S_FRD;
                    end else begin
                        r_val   <= '0;
                        r_state <= S_QRES;
                    end
                end
                S_BCMP: begin
                    if (left_s <= r_lim) begin
                        r_found  <= r_mid;
                        r_fvalid <= 1'b1;
                        r_bs_lo  <= BS_W'(r_mid) + BS_W'(1);
                    end else begin
                        r_bs_hi  <= BS_W'(r_mid) - BS_W'(1);
                    end
                    r_state <= S_BRD;
                end
                S_FRD: begin
                    r_mode  <= 1'b1;
                    r_state <= S_PWS;
                end
                S_QRES: begin
                    if (!r_q[0]) begin
                        r_a <= r_val;
                    end else if (diff > r_best) begin
                        r_best <= diff;
                    end
                    r_q <= r_q + 1'b1;
                    if (r_q == 2'd3) begin
                        if (i_next == r_cnt) begin
                            r_state <= S_OUT;
                        end else begin
                            r_i     <= PAIR_W'(i_next);
                            r_state <= S_WRD;
                        end
                    end else begin
                        r_state <= S_QST;
                    end
                end
                S_OUT: begin
                    if (!i_res_full) begin
                        r_cnt   <= '0;
                        r_drop  <= 1'b0;
                        r_bank  <= 1'b0;
                        r_w     <= PAIR_W'(1);
                        r_mode  <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end
endmodule

>>> rtl/max_window_sum_over_intervals_unit.sv
// Top level of the maximum window sum over weighted intervals unit.
//
// Intervals arrive as beats on the input queue port: a beat is taken when push is
// high and full is low. Each beat carries one interval; the beat with last_interval
// set closes the set. At most 1024 intervals per set are kept; further ones are
// dropped and reported with the result. After the closing beat the engine sorts
// the set with a two-bank merge sort, builds prefix sums and scans 4 binary
// searches per interval. The engine loads one beat per cycle and a four-beat
// queue takes input while the engine is busy; when it fills, full stays high
// until the set is finished. One result beat per set appears on the output queue
// port while empty is low and is taken when pop is high. A stalled receiver holds
// the engine once the two-entry result queue is full. The window length register
// is written with i_cfg_we and read while a set is computed. Reset is synchronous:
// all queues empty, the engine loading, window length 1.
`timescale 1ns / 1ps
module max_window_sum_over_intervals_unit import mwsi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  t_in_item               i_in_item,
    output logic                   empty,
    input  logic                   pop,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_we,
    input  logic [WINDOW_BITS-1:0] i_cfg_wdata
);
    logic [WINDOW_BITS-1:0] r_window_length;
    logic      cmd_valid;
    t_cmd      cmd;
    logic      cmd_pop;
    logic      res_push;
    t_out_item res;
    logic      res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_BITS'(1);
        end else if (i_cfg_we) begin
            r_window_length <= i_cfg_wdata;
        end
    end

    mwsi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    mwsi_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_window_length (r_window_length),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_pop       (cmd_pop),
        .o_res_push      (res_push),
        .o_res           (res),
        .i_res_full      (res_full)
    );

    mwsi_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .o_empty (empty),
        .o_data  (o_out_item),
        .i_pop   (pop)
    );
endmodule

>>> tb/mwsi_checker.sv
// Checker that predicts and compares the results of the maximum window sum unit.
`timescale 1ns / 1ps
module mwsi_checker import mwsi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    input  logic                   full,
    input  t_in_item               i_in_item,
    input  logic                   empty,
    input  logic                   pop,
    input  t_out_item              i_out_item,
    input  logic                   i_cfg_we,
    input  logic [WINDOW_BITS-1:0] i_cfg_wdata,
    output int                     o_fails,
    output int                     o_pending
);
    t_entry              set_entries[$];
    longint unsigned     set_prefix[$];
    t_out_item           expected_sums[$];
    logic                set_dropped;
    logic [WINDOW_BITS-1:0] window_len;
    int                  fails;

    assign o_fails   = fails;
    assign o_pending = expected_sums.size();

    function automatic longint unsigned weight_upto(t_entry e, longint lim);
        longint lo;
        longint hi;
        lo = longint'(e.l);
        hi = longint'(e.r);
        if (lim < hi) hi = lim;
        if (hi < lo) return 0;
        return longint'(hi - lo + 1) * longint'(e.w);
    endfunction

    function automatic longint unsigned covered_upto(longint lim);
        int lo;
        int hi;
        int mid;
        int found;
        lo = 0;
        hi = set_entries.size() - 1;
        found = -1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (longint'(set_entries[mid].l) <= lim) begin
                found = mid;
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        if (found < 0) return 0;
        return set_prefix[found] + weight_upto(set_entries[found], lim);
    endfunction

    function automatic longint unsigned window_gain(longint win_end, longint k);
        longint unsigned a;
        longint unsigned b;
        a = covered_upto(win_end);
        b = covered_upto(win_end - k);
        return (a > b) ? a - b : 0;
    endfunction

    function automatic t_out_item best_window();
        t_out_item res;
        t_entry    tmp;
        longint    k;
        longint unsigned best;
        longint unsigned g;
        int        j;
        for (int i = 1; i < set_entries.size(); i++) begin
            tmp = set_entries[i];
            j = i;
            while (j > 0 && tmp < set_entries[j-1]) begin
                set_entries[j] = set_entries[j-1];
                j--;
            end
            set_entries[j] = tmp;
        end
        set_prefix.delete();
        set_prefix.insert(0, 64'd0);
        for (int i = 0; i < set_entries.size(); i++)
            set_prefix.insert(set_prefix.size(), set_prefix[i]
                + weight_upto(set_entries[i], longint'(set_entries[i].r)));
        k = longint'(window_len);
        best = 0;
        for (int i = 0; i < set_entries.size(); i++) begin
            g = window_gain(longint'(set_entries[i].r), k);
            if (g > best) best = g;
            g = window_gain(longint'(set_entries[i].l) + k - 1, k);
            if (g > best) best = g;
        end
        if (best > 64'hFF_FFFF_FFFF) best = 64'hFF_FFFF_FFFF;
        res.best_window_sum   = best[SUM_OUT_W-1:0];
        res.capacity_exceeded = set_dropped;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            set_entries.delete();
            expected_sums.delete();
            set_dropped = 1'b0;
            window_len  = WINDOW_BITS'(1);
            fails       = 0;
        end else begin
            if (i_cfg_we) window_len = i_cfg_wdata;
            if (push && !full) begin
                if (set_entries.size() == MAX_INTERVALS) begin
                    set_dropped = 1'b1;
                end else begin
                    set_entries.insert(set_entries.size(),
                                       {i_in_item.left_end, i_in_item.right_end,
                                        i_in_item.weight_per_position});
                end
                if (i_in_item.last_interval) begin
                    expected_sums.insert(expected_sums.size(), best_window());
                    set_entries.delete();
                    set_dropped = 1'b0;
                end
            end
            if (pop && !empty) begin
                if (expected_sums.size() == 0) begin
                    $error("Result beat with no expectation: sum %0d",
                           i_out_item.best_window_sum);
                    fails++;
                end else begin
                    exp_item = expected_sums.pop_front();
                    if (i_out_item.best_window_sum !== exp_item.best_window_sum) begin
                        $error("best_window_sum: expected %0d, actual %0d",
                               exp_item.best_window_sum, i_out_item.best_window_sum);
                        fails++;
                    end
                    if (i_out_item.capacity_exceeded !== exp_item.capacity_exceeded) begin
                        $error("capacity_exceeded: expected %0d, actual %0d",
                               exp_item.capacity_exceeded, i_out_item.capacity_exceeded);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

>>> tb/max_window_sum_over_intervals_unit_tb.sv
// Testbench top of the maximum window sum unit: stimulus, reset and verdict.
`timescale 1ns / 1ps
module max_window_sum_over_intervals_unit_tb;
    import mwsi_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [WINDOW_BITS-1:0]   WIN_MAX = '1;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   push;
    logic                   full;
    t_in_item               i_in_item;
    logic                   empty;
    logic                   pop;
    t_out_item              o_out_item;
    logic                   i_cfg_we;
    logic [WINDOW_BITS-1:0] i_cfg_wdata;
    int                     fails;
    int                     pending;
    int                     idle_pct;
    bit                     hold_req;

    max_window_sum_over_intervals_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_in_item(i_in_item), .empty(empty), .pop(pop), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    mwsi_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_in_item(i_in_item), .empty(empty), .pop(pop), .i_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_fails(fails), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #40ms;
        $display("Verification failed");
        $finish;
    end

    // The receiver pops at random; on request it holds off for one long stretch.
    initial begin
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                hold_req = 1'b0;
                repeat (3000) @(posedge i_clk);
            end else begin
                pop <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    task automatic send_beat(input logic [POSITION_BITS-1:0] l, input logic [POSITION_BITS-1:0] r,
                             input logic [WEIGHT_BITS-1:0] w, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= '{left_end: l, right_end: r, weight_per_position: w, last_interval: last};
        do @(posedge i_clk); while (full);
    endtask

    task automatic set_window(input logic [WINDOW_BITS-1:0] len);
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_set(input int n, input bit narrow);
        logic [POSITION_BITS-1:0] base;
        logic [POSITION_BITS-1:0] l;
        logic [POSITION_BITS-1:0] r;
        logic [WEIGHT_BITS-1:0]   w;
        base = $urandom();
        for (int i = 0; i < n; i++) begin
            if (narrow) begin
                l = base + $urandom_range(0, 300);
                r = ($urandom_range(19) == 0) ? l - $urandom_range(1, 5)
                                              : l + $urandom_range(0, 40);
            end else begin
                l = $urandom();
                r = ($urandom_range(9) == 0) ? $urandom() : l + $urandom_range(0, 1 << 20);
            end
            w = ($urandom_range(49) == 0) ? '0 : WEIGHT_BITS'($urandom_range(1, 1023));
            send_beat(l, r, w, i == n - 1);
        end
    endtask

    initial begin
        int n;
        logic [WINDOW_BITS-1:0] len;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_in_item   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        idle_pct    = 38;
        hold_req    = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(1, 1, 1, 1'b1);
        send_beat(POS_MAX, POS_MAX, '1, 1'b1);
        send_beat(10, 20, 3, 1'b0);
        send_beat(15, 25, 4, 1'b0);
        send_beat(15, 25, 4, 1'b0);
        send_beat(30, 29, 7, 1'b0);
        send_beat(0, 5, 2, 1'b1);
        set_window(0);
        send_beat(1, 100, 9, 1'b0);
        send_beat(50, 60, '1, 1'b1);
        set_window(WIN_MAX);
        send_beat(1, POS_MAX, '1, 1'b0);
        send_beat(2, 3, 5, 1'b0);
        send_beat(0, POS_MAX, '1, 1'b1);
        set_window(3);
        send_beat(5, 9, 1, 1'b0);
        send_beat(12, 12, 8, 1'b0);
        send_beat(POS_MAX, POS_MAX, 1, 1'b0);
        send_beat(POS_MAX - 1, 2, 1, 1'b1);

        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: len = $urandom_range(1, 64);
                1: len = $urandom();
                2: len = (ph < 4) ? WIN_MAX : 1;
                default: len = $urandom_range(0, 1 << 22);
            endcase
            set_window(len);
            idle_pct = (ph == 5) ? 0 : 38;
            for (int s = 0; s < 14; s++) begin
                n = ($urandom_range(29) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
                random_set(n, $urandom_range(3) != 0);
            end
        end

        // Single-interval sets against a stalled receiver fill the block up.
        set_window(7);
        hold_req = 1'b1;
        for (int s = 0; s < 40; s++) random_set(1, 1'b1);

        // One set beyond capacity, the closing beat itself being dropped.
        set_window($urandom_range(1, 500));
        random_set(MAX_INTERVALS + 6, 1'b1);

        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
